// File: sv/wncc_pkg.sv
// Shared types, constants and ROM tables of the weighted nearest centroid classifier.
package wncc_pkg;

  localparam int unsigned NUM_CLUSTERS = 7;
  localparam int unsigned NUM_FEATURES = 8;

  localparam int unsigned FEAT_W  = 10;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned SIM_W   = 10;
  localparam int unsigned CID_W   = 3;
  localparam int unsigned CIDX_W  = $clog2(NUM_CLUSTERS);

  localparam int unsigned UNIT_SCALE = 1000;

  // Per-feature term datapath widths.
  localparam int unsigned SQ_W       = 2 * FEAT_W;
  localparam int unsigned WEIGHT_W   = 8;
  localparam int unsigned WPROD_W    = SQ_W + WEIGHT_W;
  // floor(x / 1000) = (x * RECIP_M) >> RECIP_SHIFT, exact for x below 2**WPROD_W.
  localparam int unsigned RECIP_W     = 29;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam logic [RECIP_W-1:0] RECIP_M = 29'd274877907;
  localparam int unsigned RPROD_W    = WPROD_W + RECIP_W;
  localparam int unsigned TERM_W     = 18;
  localparam int unsigned SUM_W      = TERM_W + $clog2(NUM_FEATURES);

  // Scaled distance and its square root.
  localparam int unsigned V_W         = 32;
  localparam int unsigned ROOT_W      = V_W / 2;
  localparam int unsigned ROOT_STAGES = V_W / 2;
  localparam int unsigned DP1_W       = ROOT_W + 1;
  localparam int unsigned DP1SQ_W     = 2 * DP1_W;

  // floor(d * 1000 / 3000) = floor(d / 3) = (d * RECIP3_M) >> RECIP3_SHIFT for 16-bit d.
  localparam int unsigned RECIP3_W     = 17;
  localparam int unsigned RECIP3_SHIFT = 18;
  localparam logic [RECIP3_W-1:0] RECIP3_M = 17'd87382;
  localparam int unsigned Q3_W         = ROOT_W + RECIP3_W;
  localparam int unsigned SCALED_W     = Q3_W - RECIP3_SHIFT;

  localparam int unsigned CELL_STAGES = 4;
  localparam int unsigned LATENCY     = NUM_CLUSTERS * CELL_STAGES + 1 + ROOT_STAGES + 3;

  // Configuration register map.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = CNT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SIM_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES   = 2'd1;
  localparam logic [CNT_W-1:0]     MIN_SAMPLES_RST   = 16'd10;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ROM [NUM_FEATURES] = '{
    8'd100, 8'd150, 8'd100, 8'd100, 8'd250, 8'd30, 8'd30, 8'd240
  };

  localparam logic [FEAT_W-1:0] CENTROID_ROM [NUM_CLUSTERS][NUM_FEATURES] = '{
    '{10'd400, 10'd700, 10'd800, 10'd900, 10'd800, 10'd950, 10'd600, 10'd500},
    '{10'd200, 10'd350, 10'd20,  10'd50,  10'd50,  10'd900, 10'd500, 10'd30 },
    '{10'd600, 10'd800, 10'd500, 10'd700, 10'd900, 10'd500, 10'd500, 10'd600},
    '{10'd120, 10'd50,  10'd20,  10'd20,  10'd20,  10'd950, 10'd500, 10'd110},
    '{10'd850, 10'd400, 10'd500, 10'd50,  10'd50,  10'd980, 10'd300, 10'd850},
    '{10'd100, 10'd600, 10'd700, 10'd100, 10'd950, 10'd900, 10'd500, 10'd300},
    '{10'd950, 10'd950, 10'd950, 10'd20,  10'd20,  10'd980, 10'd300, 10'd900}
  };

  localparam logic MALICIOUS_ROM [NUM_CLUSTERS] = '{
    1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1
  };

  typedef logic [NUM_FEATURES-1:0][FEAT_W-1:0] feat_vec_t;
  typedef logic [NUM_CLUSTERS-1:0][SUM_W-1:0]  sum_vec_t;

  typedef struct packed {
    logic [FEAT_W-1:0] feat_packet_size;
    logic [FEAT_W-1:0] feat_burstiness;
    logic [FEAT_W-1:0] feat_conn_rate;
    logic [FEAT_W-1:0] feat_port_spread;
    logic [FEAT_W-1:0] feat_ip_spread;
    logic [FEAT_W-1:0] feat_proto_mix;
    logic [FEAT_W-1:0] feat_time_bias;
    logic [FEAT_W-1:0] feat_entropy;
    logic [CNT_W-1:0]  sample_count;
  } req_t;

  typedef struct packed {
    logic [CID_W-1:0] cluster_id;
    logic [SIM_W-1:0] similarity;
    logic             is_malicious;
  } res_t;

  // Data handed from one centroid cell to the next.
  typedef struct packed {
    logic             enough;
    feat_vec_t        feat;
    logic [SUM_W-1:0] min_sum;
    sum_vec_t         sums;
  } link_t;

  // Data carried alongside the square root pipeline.
  typedef struct packed {
    logic     enough;
    sum_vec_t sums;
  } side_t;

endpackage

// File: sv/wncc_cell.sv
// One centroid cell: weighted squared distance to its centroid and running minimum.
module wncc_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [wncc_pkg::CIDX_W-1:0] cell_idx_i,
  input  logic                        valid_i,
  input  wncc_pkg::link_t             link_i,
  output logic                        valid_o,
  output wncc_pkg::link_t             link_o
);

  localparam int unsigned NF = wncc_pkg::NUM_FEATURES;

  logic [wncc_pkg::CELL_STAGES-1:0] vld_q;
  wncc_pkg::link_t lk1_q, lk2_q, lk3_q, out_q, out_d;

  logic [wncc_pkg::FEAT_W-1:0]  diff   [NF];
  logic [wncc_pkg::SQ_W-1:0]    sq_d   [NF];
  logic [wncc_pkg::SQ_W-1:0]    sq_q   [NF];
  logic [wncc_pkg::WPROD_W-1:0] wp_d   [NF];
  logic [wncc_pkg::WPROD_W-1:0] wp_q   [NF];
  logic [wncc_pkg::RPROD_W-1:0] rp     [NF];
  logic [wncc_pkg::TERM_W-1:0]  term_d [NF];
  logic [wncc_pkg::TERM_W-1:0]  term_q [NF];
  logic [wncc_pkg::SUM_W-1:0]   sum;

  // Stage 1: absolute difference and its square.
  always_comb begin
    for (int i = 0; i < NF; i++) begin
      if (link_i.feat[i] >= wncc_pkg::CENTROID_ROM[cell_idx_i][i]) begin
        diff[i] = link_i.feat[i] - wncc_pkg::CENTROID_ROM[cell_idx_i][i];
      end else begin
        diff[i] = wncc_pkg::CENTROID_ROM[cell_idx_i][i] - link_i.feat[i];
      end
      sq_d[i] = wncc_pkg::SQ_W'(diff[i]) * wncc_pkg::SQ_W'(diff[i]);
    end
  end

  // Stage 2: weighting. Stage 3: divide by 1000 through the reciprocal.
  always_comb begin
    for (int i = 0; i < NF; i++) begin
      wp_d[i]   = wncc_pkg::WPROD_W'(sq_q[i]) * wncc_pkg::WPROD_W'(wncc_pkg::WEIGHT_ROM[i]);
      rp[i]     = wncc_pkg::RPROD_W'(wp_q[i]) * wncc_pkg::RPROD_W'(wncc_pkg::RECIP_M);
      term_d[i] = rp[i][wncc_pkg::RECIP_SHIFT +: wncc_pkg::TERM_W];
    end
  end

  // Stage 4: sum the terms and keep the smallest sum seen along the chain.
  always_comb begin
    sum = '0;
    for (int i = 0; i < NF; i++) begin
      sum = sum + wncc_pkg::SUM_W'(term_q[i]);
    end
    out_d = lk3_q;
    out_d.sums[cell_idx_i] = sum;
    if (cell_idx_i == '0 || sum < lk3_q.min_sum) begin
      out_d.min_sum = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[wncc_pkg::CELL_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    lk1_q <= link_i;
    lk2_q <= lk1_q;
    lk3_q <= lk2_q;
    out_q <= out_d;
    for (int i = 0; i < NF; i++) begin
      sq_q[i]   <= sq_d[i];
      wp_q[i]   <= wp_d[i];
      term_q[i] <= term_d[i];
    end
  end

  assign valid_o = vld_q[wncc_pkg::CELL_STAGES-1];
  assign link_o  = out_q;

endmodule

// File: sv/wncc_sqrt.sv
// Pipelined floor square root, one result bit per stage, with a side payload.
module wncc_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [wncc_pkg::V_W-1:0]    v_i,
  input  wncc_pkg::side_t             side_i,
  output logic                        valid_o,
  output logic [wncc_pkg::ROOT_W-1:0] root_o,
  output wncc_pkg::side_t             side_o
);

  localparam int unsigned NS = wncc_pkg::ROOT_STAGES;

  logic [NS-1:0] vld_q;
  logic [wncc_pkg::V_W-1:0] rem_in  [NS];
  logic [wncc_pkg::V_W-1:0] root_in [NS];
  logic [wncc_pkg::V_W-1:0] trial   [NS];
  logic [wncc_pkg::V_W-1:0] bit_val [NS];
  logic [wncc_pkg::V_W-1:0] rem_d   [NS];
  logic [wncc_pkg::V_W-1:0] rem_q   [NS];
  logic [wncc_pkg::V_W-1:0] root_d  [NS];
  logic [wncc_pkg::V_W-1:0] root_q  [NS];
  wncc_pkg::side_t          side_in [NS];
  wncc_pkg::side_t          side_q  [NS];

  // Each stage tests one bit pair of the radicand, from the top down.
  always_comb begin
    rem_in[0]  = v_i;
    root_in[0] = '0;
    side_in[0] = side_i;
    for (int k = 1; k < NS; k++) begin
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      side_in[k] = side_q[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      bit_val[k] = wncc_pkg::V_W'(1) << (wncc_pkg::V_W - 2 - 2 * k);
      trial[k]   = root_in[k] + bit_val[k];
      if (rem_in[k] >= trial[k]) begin
        rem_d[k]  = rem_in[k] - trial[k];
        root_d[k] = (root_in[k] >> 1) + bit_val[k];
      end else begin
        rem_d[k]  = rem_in[k];
        root_d[k] = root_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
      side_q[k] <= side_in[k];
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = root_q[NS-1][wncc_pkg::ROOT_W-1:0];
  assign side_o  = side_q[NS-1];

endmodule

// File: sv/weighted_nearest_centroid_classifier.sv
// Top level of the weighted nearest centroid classifier.
// The block takes one request per clock cycle: busy_o is never raised, so a request is
// accepted at every edge with start_i high. Each request gives exactly one result, shown
// on result_o for a single cycle with result_valid_o once it has left the pipeline;
// results come out in request order and cannot be held off, so the receiver must take
// each one when it appears. The latency is set by the chain of seven centroid cells
// (four stages each, multiplier limited), the sixteen-stage square root and four stages
// of scaling and selection. Registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i and should only change while no request is in flight.
module weighted_nearest_centroid_classifier (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  wncc_pkg::req_t                  req_i,
  output logic                            result_valid_o,
  output wncc_pkg::res_t                  result_o,
  input  logic                            cfg_we_i,
  input  logic [wncc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wncc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned NC = wncc_pkg::NUM_CLUSTERS;

  logic [wncc_pkg::SIM_W-1:0] thr_q;
  logic [wncc_pkg::CNT_W-1:0] min_samples_q;

  logic            chain_vld [NC+1];
  wncc_pkg::link_t chain_lk  [NC+1];

  logic                     vvld_q;
  logic [wncc_pkg::V_W-1:0] vmin_q;
  wncc_pkg::side_t          vside_q;

  logic                        rt_vld;
  logic [wncc_pkg::ROOT_W-1:0] rt_root;
  wncc_pkg::side_t             rt_side;

  logic [wncc_pkg::DP1_W-1:0]   dp1;
  logic                         e1_vld_q, e1_enough_q;
  logic [wncc_pkg::DP1SQ_W-1:0] dp1sq_d, dp1sq_q;
  logic [wncc_pkg::Q3_W-1:0]    q3_d, q3_q;
  logic [wncc_pkg::V_W-1:0]     vc_d [NC];
  logic [wncc_pkg::V_W-1:0]     vc_q [NC];

  logic [wncc_pkg::SCALED_W-1:0] scaled;
  logic                          e2_vld_q, e2_enough_q;
  logic [NC-1:0]                 hit_d, hit_q;
  logic [wncc_pkg::SIM_W-1:0]    sim_d, sim_q;

  logic [wncc_pkg::CIDX_W-1:0] best;
  logic                        res_vld_q;
  wncc_pkg::res_t              res_d, res_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q         <= '0;
      min_samples_q <= wncc_pkg::MIN_SAMPLES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wncc_pkg::CFG_SIM_THRESHOLD: thr_q         <= cfg_wdata_i[wncc_pkg::SIM_W-1:0];
        wncc_pkg::CFG_MIN_SAMPLES:   min_samples_q <= cfg_wdata_i[wncc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    chain_vld[0]         = start_i && !busy_o;
    chain_lk[0].enough   = req_i.sample_count >= min_samples_q;
    chain_lk[0].feat[0]  = req_i.feat_packet_size;
    chain_lk[0].feat[1]  = req_i.feat_burstiness;
    chain_lk[0].feat[2]  = req_i.feat_conn_rate;
    chain_lk[0].feat[3]  = req_i.feat_port_spread;
    chain_lk[0].feat[4]  = req_i.feat_ip_spread;
    chain_lk[0].feat[5]  = req_i.feat_proto_mix;
    chain_lk[0].feat[6]  = req_i.feat_time_bias;
    chain_lk[0].feat[7]  = req_i.feat_entropy;
    chain_lk[0].min_sum  = '0;
    chain_lk[0].sums     = '0;
  end

  for (genvar c = 0; c < NC; c++) begin : g_cell
    wncc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (wncc_pkg::CIDX_W'(c)),
      .valid_i    (chain_vld[c]),
      .link_i     (chain_lk[c]),
      .valid_o    (chain_vld[c+1]),
      .link_o     (chain_lk[c+1])
    );
  end

  // Scale the smallest sum by 1000 ahead of the square root.
  always_ff @(posedge clk_i) begin
    vmin_q         <= wncc_pkg::V_W'(chain_lk[NC].min_sum) *
                      wncc_pkg::V_W'(wncc_pkg::UNIT_SCALE);
    vside_q.enough <= chain_lk[NC].enough;
    vside_q.sums   <= chain_lk[NC].sums;
  end

  wncc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vvld_q),
    .v_i     (vmin_q),
    .side_i  (vside_q),
    .valid_o (rt_vld),
    .root_o  (rt_root),
    .side_o  (rt_side)
  );

  // A centroid ties with the minimum when its scaled sum stays below (D + 1)^2, that is
  // when its own floor root equals the minimum distance D.
  always_comb begin
    dp1     = wncc_pkg::DP1_W'(rt_root) + wncc_pkg::DP1_W'(1);
    dp1sq_d = wncc_pkg::DP1SQ_W'(dp1) * wncc_pkg::DP1SQ_W'(dp1);
    q3_d    = wncc_pkg::Q3_W'(rt_root) * wncc_pkg::Q3_W'(wncc_pkg::RECIP3_M);
    for (int c = 0; c < NC; c++) begin
      vc_d[c] = wncc_pkg::V_W'(rt_side.sums[c]) * wncc_pkg::V_W'(wncc_pkg::UNIT_SCALE);
    end
  end

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      hit_d[c] = wncc_pkg::DP1SQ_W'(vc_q[c]) < dp1sq_q;
    end
    scaled = q3_q[wncc_pkg::RECIP3_SHIFT +: wncc_pkg::SCALED_W];
    if (scaled >= wncc_pkg::SCALED_W'(wncc_pkg::UNIT_SCALE)) begin
      sim_d = '0;
    end else begin
      sim_d = wncc_pkg::SIM_W'(wncc_pkg::SCALED_W'(wncc_pkg::UNIT_SCALE) - scaled);
    end
  end

  always_comb begin
    best = '0;
    for (int c = NC - 1; c >= 0; c--) begin
      if (hit_q[c]) begin
        best = wncc_pkg::CIDX_W'(c);
      end
    end
    res_d = '0;
    if (e2_enough_q) begin
      res_d.similarity = sim_q;
      if (sim_q >= thr_q) begin
        res_d.cluster_id   = wncc_pkg::CID_W'(best) + wncc_pkg::CID_W'(1);
        res_d.is_malicious = wncc_pkg::MALICIOUS_ROM[best];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vvld_q    <= 1'b0;
      e1_vld_q  <= 1'b0;
      e2_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      vvld_q    <= chain_vld[NC];
      e1_vld_q  <= rt_vld;
      e2_vld_q  <= e1_vld_q;
      res_vld_q <= e2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e1_enough_q <= rt_side.enough;
    dp1sq_q     <= dp1sq_d;
    q3_q        <= q3_d;
    for (int c = 0; c < NC; c++) begin
      vc_q[c] <= vc_d[c];
    end
    e2_enough_q <= e1_enough_q;
    hit_q       <= hit_d;
    sim_q       <= sim_d;
    res_q       <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

// File: sv/wncc_checker.sv
// Port-level checker of the classifier and its bind to the top level.
module wncc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input wncc_pkg::req_t                  req_i,
  input logic                            result_valid_o,
  input wncc_pkg::res_t                  result_o,
  input logic                            cfg_we_i,
  input logic [wncc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [wncc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [wncc_pkg::SIM_W-1:0] thr_q, thr_d;
  logic                       accept;
  logic [wncc_pkg::CNT_W-1:0] samples;

  assign accept  = start_i && !busy_o;
  assign samples = req_i.sample_count;

  // Shadow copy of the threshold register, seen from the write port.
  always_comb begin
    thr_d = thr_q;
    if (cfg_we_i && cfg_idx_i == wncc_pkg::CFG_SIM_THRESHOLD) begin
      thr_d = cfg_wdata_i[wncc_pkg::SIM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else begin
      thr_q <= thr_d;
    end
  end

  // Every accepted request yields a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(wncc_pkg::LATENCY) result_valid_o)
    else $error("accepted request gave no result after the pipeline latency");

  // No result appears without a request that latency earlier.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##(wncc_pkg::LATENCY) !result_valid_o)
    else $error("result strobe without a matching request");

  // A reported cluster always meets the threshold that was in force.
  a_threshold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.cluster_id != '0) |->
      (result_o.similarity >= $past(thr_q)))
    else $error("cluster reported below the similarity threshold");

  // Only a real cluster can be flagged malicious, and the similarity stays in range.
  a_flag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((result_o.cluster_id != '0 || !result_o.is_malicious) &&
                        result_o.similarity <= wncc_pkg::SIM_W'(wncc_pkg::UNIT_SCALE) &&
                        samples == samples))
    else $error("malicious flag without a cluster or similarity out of range");

endmodule

bind weighted_nearest_centroid_classifier wncc_checker u_wncc_checker (.*);
